/* rtl/core/tpc_pkg.sv */
package tpc_pkg;

	// Fixed-point constants, Q12.20 coordinates and Q1.30 edge parameters.
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [31:0] Z_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Z_MIN = 32'h8000_0000;
	localparam logic [63:0] HALF_Q30 = 64'h0000_0000_2000_0000;

	// Axis selector codes; any other code selects depth.
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_AXIS  = 2'd0,
		REG_PLANE = 2'd1,
		REG_SIDE  = 2'd2,
		REG_PERSP = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_REJECT = 2'd0,
		KIND_PASS   = 2'd1,
		KIND_ONE    = 2'd2,
		KIND_TWO    = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_SPARAM,
		S_SDIV,
		S_LERP,
		S_PMUL,
		S_PDEN,
		S_PDIV_GO,
		S_PDIV_WAIT,
		S_STORE,
		S_EMIT0,
		S_EMIT1
	} back_state_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec_t;

	typedef struct packed {
		logic [1:0]         axis;
		logic signed [31:0] plane;
		logic               reject_side;
		logic               persp;
	} cfg_t;

	// One clipped edge: flags for the clamped cases and the operand magnitudes.
	typedef struct packed {
		logic        s_zero;
		logic        s_one;
		logic [32:0] un;
		logic [32:0] ud;
	} span_t;

	// Classified triangle: pivot vertex, the vertex two places on, the vertex one place on.
	typedef struct packed {
		kind_t kind;
		vec_t  pv;
		vec_t  e0;
		vec_t  e1;
		span_t sp0;
		span_t sp1;
	} job_t;

	typedef struct packed {
		vec_t a;
		vec_t b;
		vec_t c;
		logic last;
	} tri_t;

	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic        ovf;
		logic [31:0] quot;
	} div_rsp_t;

	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		mag33 = v[32] ? 33'(-v) : 33'(v);
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		mag64 = v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [31:0] vsel(input vec_t v, input logic [1:0] idx);
		case (idx)
			AXIS_X: vsel = v.x;
			AXIS_Y: vsel = v.y;
			default: vsel = v.z;
		endcase
	endfunction

endpackage

/* rtl/core/tpc_div.sv */
module tpc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tpc_pkg::div_req_t  req,
	output tpc_pkg::div_rsp_t  rsp
);

	tpc_pkg::div_state_t state_q, state_d;
	logic [63:0] rem_q;
	logic [63:0] den_q;
	logic [30:0] quo_q;
	logic [4:0]  cnt_q;
	logic        ovf_q;

	logic [64:0] shifted;
	logic        ge;
	logic        ovf_d;
	logic        rnd;

	// Restoring division, one quotient bit per cycle; the first bit has weight 2^30.
	assign shifted = (cnt_q == 5'd0) ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign ge      = shifted >= {1'b0, den_q};
	assign ovf_d   = {1'b0, req.num} >= {req.den, 1'b0};
	assign rnd     = {rem_q, 1'b0} >= {1'b0, den_q};

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpc_pkg::DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: a new start always wins.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tpc_pkg::DIV_RUN: begin
				if (cnt_q == 5'd30) begin
					state_d = tpc_pkg::DIV_DONE;
				end
			end
			default: begin
			end
		endcase
		if (req.start) begin
			state_d = ovf_d ? tpc_pkg::DIV_DONE : tpc_pkg::DIV_RUN;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
			quo_q <= '0;
			cnt_q <= '0;
			ovf_q <= ovf_d;
		end else if (state_q == tpc_pkg::DIV_RUN) begin
			rem_q <= ge ? 64'(shifted - {1'b0, den_q}) : shifted[63:0];
			quo_q <= {quo_q[29:0], ge};
			cnt_q <= cnt_q + 5'd1;
		end
	end

	// Quotient rounded to nearest, ties up.
	always_comb begin
		rsp.done = (state_q == tpc_pkg::DIV_DONE);
		rsp.ovf  = ovf_q;
		rsp.quot = {1'b0, quo_q} + {31'b0, rnd};
	end

endmodule

/* rtl/core/tpc_front.sv */
module tpc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  tpc_pkg::cfg_t  cfg,
	input  logic           push,
	output logic           full,
	input  tpc_pkg::vec_t  va,
	input  tpc_pkg::vec_t  vb,
	input  tpc_pkg::vec_t  vc,
	output logic           job_valid,
	output tpc_pkg::job_t  job,
	input  logic           job_pop
);

	tpc_pkg::vec_t  v [3];
	logic [2:0]     keep;
	logic [1:0]     cnt;
	logic [1:0]     j;
	logic           tgt;
	tpc_pkg::job_t  job_d;

	tpc_pkg::job_t  ent_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     fill_q;
	logic           wr;
	logic           rd;

	function automatic tpc_pkg::span_t mk_span(input logic signed [31:0] p,
	                                           input logic signed [31:0] q,
	                                           input logic signed [31:0] plane);
		logic signed [32:0] n;
		logic signed [32:0] d;
		n = {plane[31], plane} - {p[31], p};
		d = {q[31], q} - {p[31], p};
		mk_span.s_zero = (n == '0) || (d == '0) || (n[32] != d[32]);
		mk_span.un     = tpc_pkg::mag33(n);
		mk_span.ud     = tpc_pkg::mag33(d);
		mk_span.s_one  = mk_span.un >= mk_span.ud;
	endfunction

	assign v[0] = va;
	assign v[1] = vb;
	assign v[2] = vc;

	// Classify each vertex against the plane with a one-LSB tolerance.
	always_comb begin
		logic signed [33:0] c;
		logic signed [33:0] hi;
		logic signed [33:0] lo;
		hi = {{2{cfg.plane[31]}}, cfg.plane} + 34'sd1;
		lo = {{2{cfg.plane[31]}}, cfg.plane} - 34'sd1;
		for (int i = 0; i < 3; i++) begin
			c = 34'(tpc_pkg::vsel(v[i], cfg.axis));
			keep[i] = cfg.reject_side ? !(c > hi) : !(c < lo);
		end
		cnt = 2'(keep[0]) + 2'(keep[1]) + 2'(keep[2]);
	end

	// Pivot: the lone kept vertex, or the lone rejected one.
	always_comb begin
		tgt = (cnt == 2'd1);
		if (cnt == 2'd3 || keep[0] == tgt) begin
			j = 2'd0;
		end else if (keep[1] == tgt) begin
			j = 2'd1;
		end else begin
			j = 2'd2;
		end
	end

	// Rotate the vertices around the pivot and prepare both edge divisions.
	always_comb begin
		case (cnt)
			2'd0: job_d.kind = tpc_pkg::KIND_REJECT;
			2'd1: job_d.kind = tpc_pkg::KIND_ONE;
			2'd2: job_d.kind = tpc_pkg::KIND_TWO;
			default: job_d.kind = tpc_pkg::KIND_PASS;
		endcase
		case (j)
			2'd1: begin
				job_d.pv = vb;
				job_d.e0 = va;
				job_d.e1 = vc;
			end
			2'd2: begin
				job_d.pv = vc;
				job_d.e0 = vb;
				job_d.e1 = va;
			end
			default: begin
				job_d.pv = va;
				job_d.e0 = vc;
				job_d.e1 = vb;
			end
		endcase
		job_d.sp0 = mk_span(tpc_pkg::vsel(job_d.pv, cfg.axis),
		                    tpc_pkg::vsel(job_d.e0, cfg.axis), cfg.plane);
		job_d.sp1 = mk_span(tpc_pkg::vsel(job_d.pv, cfg.axis),
		                    tpc_pkg::vsel(job_d.e1, cfg.axis), cfg.plane);
	end

	// Two-entry job queue; fully rejected triangles are dropped here.
	assign full      = (fill_q == 2'd2);
	assign wr        = push && !full && (job_d.kind != tpc_pkg::KIND_REJECT);
	assign rd        = job_pop && (fill_q != 2'd0);
	assign job_valid = (fill_q != 2'd0);
	assign job       = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= !wp_q;
			end
			if (rd) begin
				rp_q <= !rp_q;
			end
			fill_q <= fill_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wp_q] <= job_d;
		end
	end

endmodule

/* rtl/core/tpc_out_queue.sv */
module tpc_out_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  tpc_pkg::tri_t  wdata,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output tpc_pkg::tri_t  head
);

	tpc_pkg::tri_t ent_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    fill_q;
	logic          do_wr;
	logic          do_rd;

	// Two-entry result queue between the sequencer and the consumer.
	assign full  = (fill_q == 2'd2);
	assign empty = (fill_q == 2'd0);
	assign do_wr = wr && !full;
	assign do_rd = pop && !empty;
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wp_q <= !wp_q;
			end
			if (do_rd) begin
				rp_q <= !rp_q;
			end
			fill_q <= fill_q + 2'(do_wr) - 2'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wp_q] <= wdata;
		end
	end

endmodule

/* rtl/core/tpc_back.sv */
module tpc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tpc_pkg::cfg_t      cfg,
	input  logic               job_valid,
	input  tpc_pkg::job_t      job,
	output logic               job_pop,
	output tpc_pkg::div_req_t  div_req,
	input  tpc_pkg::div_rsp_t  div_rsp,
	output logic               out_wr,
	output tpc_pkg::tri_t      out_data,
	input  logic               out_full
);

	tpc_pkg::back_state_t state_q, state_d;

	tpc_pkg::job_t      job_q;
	logic               e_q;
	logic [30:0]        s_q;
	logic [1:0]         c_q;
	logic [63:0]        prod_q;
	logic               pneg_q;
	logic signed [31:0] pbase_q;
	tpc_pkg::vec_t      pt_q;
	tpc_pkg::vec_t      p0_q;
	tpc_pkg::vec_t      p1_q;
	logic signed [63:0] num_q;
	logic signed [63:0] dprod_q;
	logic signed [63:0] den_q;
	logic               zneg_q;

	tpc_pkg::vec_t      qv;
	tpc_pkg::span_t     sp;
	logic signed [31:0] pc;
	logic signed [31:0] qc;
	logic signed [32:0] diff;
	logic               pneg_d;
	logic [63:0]        prod_d;
	logic [33:0]        m;
	logic [33:0]        lerp_res;
	logic [1:0]         cidx;
	logic signed [32:0] dz;
	logic [31:0]        z_res;

	// Current edge: endpoint and division operands.
	assign qv = e_q ? job_q.e1 : job_q.e0;
	assign sp = e_q ? job_q.sp1 : job_q.sp0;

	// Linear interpolation, one coordinate per cycle: multiply, then round and add.
	assign pc       = tpc_pkg::vsel(job_q.pv, c_q);
	assign qc       = tpc_pkg::vsel(qv, c_q);
	assign diff     = {qc[31], qc} - {pc[31], pc};
	assign pneg_d   = diff[32];
	assign prod_d   = 64'(tpc_pkg::mag33(diff)) * 64'(s_q);
	assign m        = 34'((prod_q + tpc_pkg::HALF_Q30) >> 30);
	assign lerp_res = pneg_q ? ({{2{pbase_q[31]}}, pbase_q} - m)
	                         : ({{2{pbase_q[31]}}, pbase_q} + m);
	assign cidx     = c_q - 2'd1;
	assign dz       = {job_q.pv.z[31], job_q.pv.z} - {qv.z[31], qv.z};

	// Harmonic depth from the divider, signed and saturated.
	always_comb begin
		if (div_rsp.ovf) begin
			z_res = zneg_q ? tpc_pkg::Z_MIN : tpc_pkg::Z_MAX;
		end else if (zneg_q) begin
			z_res = 32'(-div_rsp.quot);
		end else begin
			z_res = div_rsp.quot[31] ? tpc_pkg::Z_MAX : div_rsp.quot;
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, queue handshakes and divider requests.
	always_comb begin
		state_d        = state_q;
		job_pop        = 1'b0;
		out_wr         = 1'b0;
		div_req.start  = 1'b0;
		div_req.num    = {31'b0, sp.un};
		div_req.den    = {31'b0, sp.ud};
		out_data.a     = job_q.pv;
		out_data.b     = job_q.e1;
		out_data.c     = job_q.e0;
		out_data.last  = 1'b1;
		case (job_q.kind)
			tpc_pkg::KIND_ONE: begin
				out_data.a = p0_q;
				out_data.b = job_q.pv;
				out_data.c = p1_q;
			end
			tpc_pkg::KIND_TWO: begin
				out_data.a = job_q.e0;
				if (state_q == tpc_pkg::S_EMIT1) begin
					out_data.b = p1_q;
					out_data.c = job_q.e1;
				end else begin
					out_data.b    = p0_q;
					out_data.c    = p1_q;
					out_data.last = 1'b0;
				end
			end
			default: begin
			end
		endcase
		case (state_q)
			tpc_pkg::S_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = tpc_pkg::S_START;
				end
			end
			tpc_pkg::S_START: begin
				case (job_q.kind)
					tpc_pkg::KIND_PASS: state_d = tpc_pkg::S_EMIT0;
					tpc_pkg::KIND_ONE: state_d = tpc_pkg::S_SPARAM;
					tpc_pkg::KIND_TWO: state_d = tpc_pkg::S_SPARAM;
					default: state_d = tpc_pkg::S_IDLE;
				endcase
			end
			tpc_pkg::S_SPARAM: begin
				if (sp.s_zero || sp.s_one) begin
					state_d = tpc_pkg::S_LERP;
				end else begin
					div_req.start = 1'b1;
					state_d       = tpc_pkg::S_SDIV;
				end
			end
			tpc_pkg::S_SDIV: begin
				if (div_rsp.done) begin
					state_d = tpc_pkg::S_LERP;
				end
			end
			tpc_pkg::S_LERP: begin
				if (c_q == 2'd3) begin
					state_d = cfg.persp ? tpc_pkg::S_PMUL : tpc_pkg::S_STORE;
				end
			end
			tpc_pkg::S_PMUL: begin
				state_d = tpc_pkg::S_PDEN;
			end
			tpc_pkg::S_PDEN: begin
				state_d = tpc_pkg::S_PDIV_GO;
			end
			tpc_pkg::S_PDIV_GO: begin
				div_req.num = tpc_pkg::mag64(num_q);
				div_req.den = tpc_pkg::mag64(den_q);
				if (den_q == '0) begin
					state_d = tpc_pkg::S_STORE;
				end else begin
					div_req.start = 1'b1;
					state_d       = tpc_pkg::S_PDIV_WAIT;
				end
			end
			tpc_pkg::S_PDIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = tpc_pkg::S_STORE;
				end
			end
			tpc_pkg::S_STORE: begin
				state_d = e_q ? tpc_pkg::S_EMIT0 : tpc_pkg::S_SPARAM;
			end
			tpc_pkg::S_EMIT0: begin
				if (!out_full) begin
					out_wr  = 1'b1;
					state_d = (job_q.kind == tpc_pkg::KIND_TWO) ? tpc_pkg::S_EMIT1
					                                            : tpc_pkg::S_IDLE;
				end
			end
			tpc_pkg::S_EMIT1: begin
				if (!out_full) begin
					out_wr  = 1'b1;
					state_d = tpc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tpc_pkg::S_IDLE;
			end
		endcase
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			tpc_pkg::S_IDLE: begin
				if (job_valid) begin
					job_q <= job;
				end
				e_q <= 1'b0;
			end
			tpc_pkg::S_SPARAM: begin
				c_q <= 2'd0;
				if (sp.s_zero) begin
					s_q <= '0;
				end else if (sp.s_one) begin
					s_q <= tpc_pkg::ONE_Q30;
				end
			end
			tpc_pkg::S_SDIV: begin
				s_q <= div_rsp.quot[30:0];
			end
			tpc_pkg::S_LERP: begin
				prod_q  <= prod_d;
				pneg_q  <= pneg_d;
				pbase_q <= pc;
				if (c_q != 2'd0) begin
					case (cidx)
						tpc_pkg::AXIS_X: pt_q.x <= lerp_res[31:0];
						tpc_pkg::AXIS_Y: pt_q.y <= lerp_res[31:0];
						default: pt_q.z <= lerp_res[31:0];
					endcase
				end
				c_q <= c_q + 2'd1;
			end
			tpc_pkg::S_PMUL: begin
				num_q   <= 64'(job_q.pv.z) * 64'(qv.z);
				dprod_q <= 64'($signed({1'b0, s_q})) * 64'(dz);
			end
			tpc_pkg::S_PDEN: begin
				den_q <= (64'(qv.z) <<< 30) + dprod_q;
			end
			tpc_pkg::S_PDIV_GO: begin
				zneg_q <= num_q[63] ^ den_q[63];
				if (den_q == '0) begin
					pt_q <= job_q.pv;
				end
			end
			tpc_pkg::S_PDIV_WAIT: begin
				if (div_rsp.done) begin
					pt_q.z <= z_res;
				end
			end
			tpc_pkg::S_STORE: begin
				if (e_q) begin
					p1_q <= pt_q;
				end else begin
					p0_q <= pt_q;
				end
				e_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/core/triangle_plane_clipper.sv */
// Triangle clipper against an axis-aligned plane.
// Input channel: a triangle transaction is taken when push is high and full is
// low. A front classifier sorts the vertices against the plane and places the
// work in a two-entry job queue, so input keeps flowing while the back end works.
// Result channel: empty low means a result triangle is on the out ports; it is
// taken when pop is high. last_piece marks the final triangle of an input.
// A back-end sequencer builds the new edge points; one shared divider, one
// quotient bit per cycle, sets the cost of a clipped triangle:
//   fully rejected: consumed by the classifier, no result;
//   fully kept: passed through the back end without the divider;
//   clipped: up to one division per new edge point, two in perspective mode.
// The user writes configuration over the APB-style port only while the block
// is idle; the block itself does not enforce this. Reset empties both queues,
// clears the configuration registers and returns the sequencer to idle.
// When the consumer stalls, the result queue fills, the sequencer waits, then
// the job queue fills and full rises; nothing is lost.
module triangle_plane_clipper (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic signed [31:0] c_x,
	input  logic signed [31:0] c_y,
	input  logic signed [31:0] c_z,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] out_a_x,
	output logic signed [31:0] out_a_y,
	output logic signed [31:0] out_a_z,
	output logic signed [31:0] out_b_x,
	output logic signed [31:0] out_b_y,
	output logic signed [31:0] out_b_z,
	output logic signed [31:0] out_c_x,
	output logic signed [31:0] out_c_y,
	output logic signed [31:0] out_c_z,
	output logic               last_piece
);

	tpc_pkg::cfg_t     cfg_q;
	tpc_pkg::reg_idx_t ridx;
	logic              cfg_wr;

	tpc_pkg::vec_t     va;
	tpc_pkg::vec_t     vb;
	tpc_pkg::vec_t     vc;
	logic              job_valid;
	tpc_pkg::job_t     job;
	logic              job_pop;
	tpc_pkg::div_req_t div_req;
	tpc_pkg::div_rsp_t div_rsp;
	logic              out_wr;
	tpc_pkg::tri_t     out_data;
	logic              out_full;
	tpc_pkg::tri_t     head;

	// Configuration registers, written in the access phase.
	assign pready = 1'b1;
	assign ridx   = tpc_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (ridx)
				tpc_pkg::REG_AXIS: cfg_q.axis <= pwdata[1:0];
				tpc_pkg::REG_PLANE: cfg_q.plane <= pwdata;
				tpc_pkg::REG_SIDE: cfg_q.reject_side <= pwdata[0];
				tpc_pkg::REG_PERSP: cfg_q.persp <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (ridx)
			tpc_pkg::REG_AXIS: prdata = {30'b0, cfg_q.axis};
			tpc_pkg::REG_PLANE: prdata = cfg_q.plane;
			tpc_pkg::REG_SIDE: prdata = {31'b0, cfg_q.reject_side};
			tpc_pkg::REG_PERSP: prdata = {31'b0, cfg_q.persp};
			default: prdata = '0;
		endcase
	end

	assign va = '{x: a_x, y: a_y, z: a_z};
	assign vb = '{x: b_x, y: b_y, z: b_z};
	assign vc = '{x: c_x, y: c_y, z: c_z};

	tpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.full      (full),
		.va        (va),
		.vb        (vb),
		.vc        (vc),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	tpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.out_wr    (out_wr),
		.out_data  (out_data),
		.out_full  (out_full)
	);

	tpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tpc_out_queue u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (out_wr),
		.wdata  (out_data),
		.full   (out_full),
		.pop    (pop),
		.empty  (empty),
		.head   (head)
	);

	// Result ports.
	assign out_a_x    = head.a.x;
	assign out_a_y    = head.a.y;
	assign out_a_z    = head.a.z;
	assign out_b_x    = head.b.x;
	assign out_b_y    = head.b.y;
	assign out_b_z    = head.b.z;
	assign out_c_x    = head.c.x;
	assign out_c_y    = head.c.y;
	assign out_c_z    = head.c.z;
	assign last_piece = head.last;

endmodule

/* tb/sv/tb_triangle_plane_clipper.sv */
`timescale 1ns / 100ps

module tb_triangle_plane_clipper;

	localparam int SETTLE_CYCLES = 400;

	// One vertex and one result triangle in the testbench's own terms.
	typedef struct {
		longint x;
		longint y;
		longint z;
	} vtx_t;

	typedef struct {
		logic [31:0] f[9];
		logic        last;
	} piece_t;

	typedef struct {
		logic [31:0] f[9];
		int          n_exp;
		logic [31:0] e0[9];
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        push, full, empty, pop;
	logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
	logic signed [31:0] out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z;
	logic signed [31:0] out_c_x, out_c_y, out_c_z;
	logic        last_piece;

	// Shadow copy of the clip setup.
	logic [1:0]  sh_axis;
	longint      sh_plane;
	logic        sh_side;
	logic        sh_persp;

	piece_t      expected_pieces[$];
	int          error_count;
	int          pieces_seen;
	bit          hold_off;
	bit          hold_done;

	triangle_plane_clipper dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.c_x(c_x), .c_y(c_y), .c_z(c_z),
		.empty(empty), .pop(pop),
		.out_a_x(out_a_x), .out_a_y(out_a_y), .out_a_z(out_a_z),
		.out_b_x(out_b_x), .out_b_y(out_b_y), .out_b_z(out_b_z),
		.out_c_x(out_c_x), .out_c_y(out_c_y), .out_c_z(out_c_z),
		.last_piece(last_piece)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("TB_ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		error_count++;
	endtask

	// Append one piece to the list of expected results.
	task automatic expect_piece(input piece_t p);
		expected_pieces.insert(expected_pieces.size(), p);
	endtask

	function automatic longint sext32(input logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic longint abs64(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// Edge crossing parameter in Q1.30, clamped to [0, 1].
	function automatic longint crossing_param(input longint p, input longint q);
		longint n, d, un, ud;
		n = sh_plane - p;
		d = q - p;
		if (n == 0 || d == 0 || ((n < 0) != (d < 0)))
			return 0;
		un = abs64(n);
		ud = abs64(d);
		if (un >= ud)
			return 64'd1073741824;
		return ((un << 30) + (ud >> 1)) / ud;
	endfunction

	function automatic longint blend(input longint p, input longint q, input longint s);
		longint d;
		logic [63:0] m;
		d = q - p;
		m = (64'(abs64(d)) * 64'(s) + 64'h2000_0000) >> 30;
		return d < 0 ? p - longint'(m) : p + longint'(m);
	endfunction

	// Rounded, saturated num * 2^30 / den with a wide intermediate.
	function automatic longint harmonic_div(input longint num, input longint den);
		bit neg;
		logic [127:0] un, ud, q, r;
		neg = (num < 0) != (den < 0);
		un = 128'(abs64(num));
		ud = 128'(abs64(den));
		if (un / ud >= 2)
			return neg ? -64'sd2147483648 : 64'sd2147483647;
		q = (un << 30) / ud;
		r = (un << 30) % ud;
		if ((r << 1) >= ud)
			q = q + 1;
		if (neg)
			return -longint'(q);
		return q > 128'h7FFF_FFFF ? 64'sd2147483647 : longint'(q);
	endfunction

	function automatic vtx_t edge_cut(input vtx_t p, input vtx_t q, input longint s);
		vtx_t o;
		longint den;
		o.x = blend(p.x, q.x, s);
		o.y = blend(p.y, q.y, s);
		if (!sh_persp) begin
			o.z = blend(p.z, q.z, s);
			return o;
		end
		den = q.z * 64'sd1073741824 + s * (p.z - q.z);
		if (den == 0)
			return p;
		o.z = harmonic_div(p.z * q.z, den);
		return o;
	endfunction

	function automatic longint axis_coord(input vtx_t v);
		case (sh_axis)
			tpc_pkg::AXIS_X: return v.x;
			tpc_pkg::AXIS_Y: return v.y;
			default: return v.z;
		endcase
	endfunction

	function automatic piece_t make_piece(input vtx_t a, input vtx_t b, input vtx_t c,
			input logic last);
		piece_t t;
		t.f[0] = a.x[31:0]; t.f[1] = a.y[31:0]; t.f[2] = a.z[31:0];
		t.f[3] = b.x[31:0]; t.f[4] = b.y[31:0]; t.f[5] = b.z[31:0];
		t.f[6] = c.x[31:0]; t.f[7] = c.y[31:0]; t.f[8] = c.z[31:0];
		t.last = last;
		return t;
	endfunction

	// Clip one triangle and queue the pieces it yields.
	task automatic clip_triangle(input logic [31:0] f[9]);
		vtx_t v[3], p0, p1;
		bit keep[3];
		int cnt, j, k1, k2;
		longint c;
		cnt = 0;
		for (int i = 0; i < 3; i++) begin
			v[i].x = sext32(f[3*i]);
			v[i].y = sext32(f[3*i+1]);
			v[i].z = sext32(f[3*i+2]);
			c = axis_coord(v[i]);
			keep[i] = sh_side ? !(c > sh_plane + 1) : !(c < sh_plane - 1);
			cnt += keep[i];
		end
		if (cnt == 0)
			return;
		if (cnt == 3) begin
			expect_piece(make_piece(v[0], v[1], v[2], 1'b1));
			return;
		end
		j = 0;
		while (j < 2 && keep[j] != (cnt == 1))
			j++;
		k1 = (j + 1) % 3;
		k2 = (j + 2) % 3;
		p0 = edge_cut(v[j], v[k2], crossing_param(axis_coord(v[j]), axis_coord(v[k2])));
		p1 = edge_cut(v[j], v[k1], crossing_param(axis_coord(v[j]), axis_coord(v[k1])));
		if (cnt == 1) begin
			expect_piece(make_piece(p0, v[j], p1, 1'b1));
		end else begin
			expect_piece(make_piece(v[k2], p0, p1, 1'b0));
			expect_piece(make_piece(v[k2], p1, v[k1], 1'b1));
		end
	endtask

	// Register write: setup cycle then access cycle.
	task automatic write_reg(input tpc_pkg::reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			tpc_pkg::REG_AXIS: sh_axis = val[1:0];
			tpc_pkg::REG_PLANE: sh_plane = sext32(val);
			tpc_pkg::REG_SIDE: sh_side = val[0];
			default: sh_persp = val[0];
		endcase
	endtask

	// Stop offering triangles.
	task automatic idle_input();
		push <= 1'b0;
	endtask

	task automatic set_clip(input logic [1:0] ax, input logic [31:0] pl, input logic sd,
			input logic ps);
		idle_input();
		while (expected_pieces.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(tpc_pkg::REG_AXIS, {30'd0, ax});
		write_reg(tpc_pkg::REG_PLANE, pl);
		write_reg(tpc_pkg::REG_SIDE, {31'd0, sd});
		write_reg(tpc_pkg::REG_PERSP, {31'd0, ps});
	endtask

	function automatic int short_gap();
		return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
			: ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
	endfunction

	// Offer one triangle and wait until it is accepted; push stays high when
	// the next one follows without a gap.
	task automatic send_triangle(input logic [31:0] f[9], input bit predict);
		int gap;
		gap = short_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		a_x <= f[0]; a_y <= f[1]; a_z <= f[2];
		b_x <= f[3]; b_y <= f[4]; b_z <= f[5];
		c_x <= f[6]; c_y <= f[7]; c_z <= f[8];
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (predict)
			clip_triangle(f);
	endtask

	// Coordinate near the plane most of the time, anywhere otherwise.
	function automatic logic [31:0] rand_coord();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 32'(sh_plane + $signed($urandom_range(0, 2 << 22)) - (1 << 22));
		if (r < 7)
			return 32'(sh_plane + $signed($urandom_range(0, 4)) - 2);
		if (r < 8)
			return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		return $urandom;
	endfunction

	task automatic random_burst(input int count);
		logic [31:0] f[9];
		for (int n = 0; n < count; n++) begin
			foreach (f[i])
				f[i] = rand_coord();
			send_triangle(f, 1'b1);
		end
	endtask

	// Result side: random stalls plus one long hold-off counted here.
	initial begin
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				pop <= 1'b0;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
				hold_done = 1'b1;
			end else if ($urandom_range(0, 30) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(5, 50)) @(posedge clk);
			end else begin
				pop <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	// Compare each accepted piece with the oldest expected one.
	always @(posedge clk) begin
		piece_t got, want;
		if (arst_n && pop && !empty) begin
			got.f[0] = out_a_x; got.f[1] = out_a_y; got.f[2] = out_a_z;
			got.f[3] = out_b_x; got.f[4] = out_b_y; got.f[5] = out_b_z;
			got.f[6] = out_c_x; got.f[7] = out_c_y; got.f[8] = out_c_z;
			got.last = last_piece;
			pieces_seen++;
			if (expected_pieces.size() == 0) begin
				report_mismatch("unexpected result transaction");
			end else begin
				want = expected_pieces.pop_front();
				for (int i = 0; i < 9; i++)
					if (got.f[i] !== want.f[i])
						report_mismatch($sformatf("piece %0d coord %0d got %h want %h",
							pieces_seen, i, got.f[i], want.f[i]));
				if (got.last !== want.last)
					report_mismatch($sformatf("piece %0d last_piece got %b want %b",
						pieces_seen, got.last, want.last));
			end
		end
	end

	// Directed table: rows with a fixed answer are checked directly.
	dir_row_t dir_rows[$];

	task automatic add_row(input logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz,
			input int n_exp);
		dir_row_t r;
		r.f = '{ax, ay, az, bx, by, bz, cx, cy, cz};
		r.n_exp = n_exp;
		r.e0 = r.f;
		dir_rows.insert(dir_rows.size(), r);
	endtask

	initial begin
		logic [31:0] one;
		int timeout;
		piece_t t;
		one = 32'h0010_0000;
		error_count = 0;
		pieces_seen = 0;
		hold_off = 0;
		hold_done = 0;
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		push = 0;
		{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
		sh_axis = 0; sh_plane = 0; sh_side = 0; sh_persp = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes: all kept passes through, all rejected gives nothing; minus one
		// lies within the tolerance of a zero plane and is kept.
		add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0,
			32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1);
		add_row(32'h8000_0000, 0, 0, 32'hFFFF_FFFE, 0, 0, 32'h8000_0001, 0, 0, 0);
		add_row(32'hFFFF_FFFF, 1, 2, 32'hFFFF_FFFF, 3, 4, 32'hFFFF_FFFF, 5, 6, 1);
		// One kept, two kept (each rotation), through the predictor.
		add_row(one, one, one, -one, 0, one, -one, one, 0, -1);
		add_row(-one, one, one, one, 0, one, -one, one, 0, -1);
		add_row(-one, one, one, -one, 0, one, one, one, 0, -1);
		add_row(-one, one, one, one, 0, one, one, one, 0, -1);
		add_row(one, one, one, -one, 0, one, one, one, 0, -1);
		add_row(one, one, one, one, 0, one, -one, one, 0, -1);
		add_row(32'h7FFF_FFFF, 5, 7, 32'h8000_0000, 9, 11, 32'h8000_0000, 3, 1, -1);
		add_row(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 0, 0, 0, -1);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].n_exp < 0) begin
				send_triangle(dir_rows[i].f, 1'b1);
			end else begin
				send_triangle(dir_rows[i].f, 1'b0);
				if (dir_rows[i].n_exp == 1) begin
					t.f = dir_rows[i].e0;
					t.last = 1'b1;
					expect_piece(t);
				end
			end
		end

		// Perspective on depth axis, zero depths and coincident rays included.
		set_clip(2'd2, 32'h0000_0000, 1'b1, 1'b1);
		add_row(0, 0, 0, one, one, one, 2*one, one, -one, -1);
		dir_rows = dir_rows[$:$];
		send_triangle(dir_rows[0].f, 1'b1);
		dir_rows[0].f = '{one, one, one, one, one, -one, one, one, 32'h7FFF_FFFF};
		send_triangle(dir_rows[0].f, 1'b1);
		dir_rows[0].f = '{0, 0, -one, 0, 0, 0, 3, 3, 32'h8000_0000};
		send_triangle(dir_rows[0].f, 1'b1);
		random_burst(60);

		// Stall the result side long enough that the input backs up.
		set_clip(2'd1, 32'hFFF0_0000, 1'b0, 1'b0);
		hold_off = 1;
		random_burst(30);
		wait (hold_done);
		random_burst(50);

		set_clip(2'd3, 32'h7FFF_FFFF, 1'b0, 1'b1);
		random_burst(50);
		set_clip(2'd0, 32'h8000_0000, 1'b1, 1'b0);
		random_burst(50);
		set_clip(2'd0, $urandom, 1'b0, 1'b1);
		random_burst(80);
		set_clip(2'd2, 32'h0123_4567, 1'b1, 1'b0);
		random_burst(80);
		set_clip(2'd1, 32'h8000_0001, 1'b1, 1'b1);
		random_burst(50);
		idle_input();

		timeout = 0;
		while (expected_pieces.size() != 0 && timeout < 200000) begin
			@(posedge clk);
			timeout++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_pieces.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/tpc_pkg.sv
rtl/core/tpc_div.sv
rtl/core/tpc_front.sv
rtl/core/tpc_out_queue.sv
rtl/core/tpc_back.sv
rtl/core/triangle_plane_clipper.sv
tb/sv/tb_triangle_plane_clipper.sv
